/* hw/rtl/block_map_sync_tracker_defines.svh */
`ifndef BLOCK_MAP_SYNC_TRACKER_DEFINES_SVH
`define BLOCK_MAP_SYNC_TRACKER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define BMST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define BMST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bmst_pkg.sv */
`default_nettype none
package bmst_pkg;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_REJECT = 3'd1,
        ST_RESET  = 3'd2,
        ST_REQ    = 3'd3,
        ST_SKIP   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ACT_WINDOW = 2'd0,
        ACT_SEQ    = 2'd1,
        ACT_HEADER = 2'd2,
        ACT_DATA   = 2'd3
    } t_action;

    localparam logic CFG_OWN_TYPE = 1'b0;
    localparam logic CFG_FILL     = 1'b1;

    typedef enum logic [2:0] {
        K_NOP,
        K_CLEAR,
        K_CMP,
        K_WRSEQ,
        K_UNPACK
    } t_kind;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CLEAR,
        BS_CMP_RD,
        BS_CMP_CHK,
        BS_WSEQ,
        BS_UNPACK,
        BS_EMIT
    } t_bstate;

    // widths sized for the largest map the parameters allow; modules use low bits
    typedef struct packed {
        t_kind             kind;
        t_status           status;
        logic signed [7:0] rx;
        logic signed [7:0] ry;
        logic              last;
        logic [15:0]       seq;
        logic [13:0]       blk_addr;
        logic [25:0]       cell_addr;
        logic [5:0]        col;
        logic [3:0]        ncell;
        logic [3:0]        bpc;
        logic [7:0]        pbyte;
        logic [7:0]        fill;
    } t_op;

endpackage
`default_nettype wire

/* hw/rtl/bmst_if.sv */
`default_nettype none
interface bmst_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic signed [7:0] item_map_type;
    logic signed [7:0] win_x_first;
    logic signed [7:0] win_x_stop;
    logic signed [7:0] win_y_first;
    logic signed [7:0] win_y_stop;
    logic [15:0]       seq_value;
    logic signed [7:0] blk_x;
    logic signed [7:0] blk_y;
    logic [7:0]        packed_byte;
    logic [3:0]        bits_per_cell;

    modport source (output valid, action, item_map_type, win_x_first, win_x_stop,
                    win_y_first, win_y_stop, seq_value, blk_x, blk_y, packed_byte,
                    bits_per_cell, input ready);
    modport sink (input valid, action, item_map_type, win_x_first, win_x_stop,
                  win_y_first, win_y_stop, seq_value, blk_x, blk_y, packed_byte,
                  bits_per_cell, output ready);
endinterface

interface bmst_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic signed [7:0] req_x;
    logic signed [7:0] req_y;
    logic              run_last;

    modport source (output valid, status, req_x, req_y, run_last, input ready);
    modport sink (input valid, status, req_x, req_y, run_last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/block_map_sync_tracker.sv */
// The back end runs one op at a time and starts the next only after handing the result of the
// last to the output register, waiting in its emit state while the output stalls; the
// two-entry queue lets the front run ahead meanwhile.
// Synchronous active-low reset; afterwards a clearing pass over all BLOCKS_X*BLOCKS_Y*
// BLOCK_SIZE^2 cells (262144 by default) holds input ready low; config is taken.
`default_nettype none
`include "block_map_sync_tracker_defines.svh"
module block_map_sync_tracker #(
    parameter int BLOCK_SIZE = 16,
    parameter int BLOCKS_X   = 32,
    parameter int BLOCKS_Y   = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    bmst_in_if.sink         i_in,
    bmst_out_if.source      o_out,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);
    import bmst_pkg::*;

    logic q_push, q_full, q_pop, q_empty, init;
    t_op  push_op, head_op;

    bmst_front #(.BLOCK_SIZE(BLOCK_SIZE), .BLOCKS_X(BLOCKS_X), .BLOCKS_Y(BLOCKS_Y)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .i_init     (init),
        .o_push     (q_push),
        .o_op       (push_op)
    );

    bmst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (head_op),
        .o_empty (q_empty)
    );

    bmst_back #(.BLOCK_SIZE(BLOCK_SIZE), .BLOCKS_X(BLOCKS_X), .BLOCKS_Y(BLOCKS_Y)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_op      (head_op),
        .o_pop     (q_pop),
        .o_init    (init),
        .o_out     (o_out)
    );

    `BMST_ASSERT_IMP(a_no_push_full, q_push, !q_full, "push into full queue")
    `BMST_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty, "pop from empty queue")
    `BMST_ASSERT_IMP(a_no_accept_init, init, !i_in.ready, "transfer during clearing pass")
    `BMST_ASSERT_NXT(a_push_lands, q_push && !q_pop && q_empty, !q_empty, "pushed op lost")
endmodule
`default_nettype wire

/* hw/rtl/bmst_ram.sv */
`default_nettype none
module bmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* hw/rtl/bmst_queue.sv */
`default_nettype none
module bmst_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bmst_pkg::t_op i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output bmst_pkg::t_op      o_data,
    output logic               o_empty
);
    import bmst_pkg::*;

    t_op        r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;

    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
endmodule
`default_nettype wire

/* hw/rtl/bmst_front.sv */
`default_nettype none
module bmst_front #(
    parameter int BLOCK_SIZE = 16,
    parameter int BLOCKS_X   = 32,
    parameter int BLOCKS_Y   = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    bmst_in_if.sink         i_in,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_q_full,
    input  wire logic       i_init,
    output logic            o_push,
    output bmst_pkg::t_op   o_op
);
    import bmst_pkg::*;

    localparam int MAP_W = BLOCKS_X * BLOCK_SIZE;
    localparam int CPB   = BLOCK_SIZE * BLOCK_SIZE;
    localparam int XW    = $clog2(BLOCKS_X + 1);
    localparam int YW    = $clog2(BLOCKS_Y + 1);
    localparam int CURW  = $clog2(CPB + 1);
    localparam int COLW  = $clog2(BLOCK_SIZE);
    localparam int CAW   = $clog2(BLOCKS_X * BLOCKS_Y * CPB);
    localparam int BAW   = $clog2(BLOCKS_X * BLOCKS_Y);
    localparam logic signed [9:0] HXS = 10'(BLOCKS_X / 2);
    localparam logic signed [9:0] HYS = 10'(BLOCKS_Y / 2);
    localparam logic signed [9:0] BXS = 10'(BLOCKS_X);
    localparam logic signed [9:0] BYS = 10'(BLOCKS_Y);

    function automatic logic signed [9:0] sx(input logic [7:0] v);
        return {{2{v[7]}}, v};
    endfunction

    logic signed [7:0] r_own;
    logic [7:0]        r_fill;
    logic [XW-1:0]     r_u0, r_u1, r_cu;
    logic [YW-1:0]     r_v0, r_v1, r_cv;
    logic              r_wv;
    logic              r_ua;
    logic [CURW-1:0]   r_cur;
    logic [COLW-1:0]   r_col;
    logic [CAW-1:0]    r_addr;
    logic [3:0]        r_bpc;

    logic [XW-1:0]   n_u0, n_u1, n_cu;
    logic [YW-1:0]   n_v0, n_v1, n_cv;
    logic            n_wv, n_ua;
    logic [CURW-1:0] n_cur;
    logic [COLW-1:0] n_col;
    logic [CAW-1:0]  n_addr;
    logic [3:0]      n_bpc;

    logic signed [9:0] u0, u1, v0, v1, hu, hv;
    logic signed [9:0] hu0, hu1, hv0, hv1;
    logic              type_ok, win_bad, map_rst, cmp_ok, hdr_ok, bpc_ok;
    logic [1:0]        sh;
    logic [3:0]        nfull, ncell;
    logic [CURW-1:0]   rem;
    logic [COLW:0]     c2;
    logic              dlast;
    logic              acc;
    t_op               op;

    assign acc      = i_in.valid && i_in.ready;
    assign i_in.ready = !i_q_full && !i_init;

    always_comb begin
        type_ok = (i_in.item_map_type == r_own);
        hu0 = $signed(10'(r_u0));
        hu1 = $signed(10'(r_u1));
        hv0 = $signed(10'(r_v0));
        hv1 = $signed(10'(r_v1));
        u0 = sx(i_in.win_x_first) + HXS;
        u1 = sx(i_in.win_x_stop) + HXS;
        v0 = sx(i_in.win_y_first) + HYS;
        v1 = sx(i_in.win_y_stop) + HYS;
        win_bad = (u0 < 10'sd0) || (u0 > u1) || (u1 > BXS) ||
                  (v0 < 10'sd0) || (v0 > v1) || (v1 > BYS);
        map_rst = (u0 > hu0) || (v0 > hv0) || (u1 < hu1) || (v1 < hv1);
        cmp_ok  = r_wv && type_ok && (r_u0 < r_u1) && (r_cv < r_v1);
        hu = sx(i_in.blk_x) + HXS;
        hv = sx(i_in.blk_y) + HYS;
        bpc_ok = (i_in.bits_per_cell == 4'd1) || (i_in.bits_per_cell == 4'd2) ||
                 (i_in.bits_per_cell == 4'd4) || (i_in.bits_per_cell == 4'd8);
        hdr_ok = type_ok && r_wv && bpc_ok &&
                 (hu >= hu0) && (hu < hu1) && (hv >= hv0) && (hv < hv1);

        unique case (r_bpc)
            4'd1:    sh = 2'd0;
            4'd2:    sh = 2'd1;
            4'd4:    sh = 2'd2;
            default: sh = 2'd3;
        endcase
        nfull = 4'd8 >> sh;
        rem   = CURW'(CPB) - r_cur;
        ncell = (rem < CURW'(nfull)) ? rem[3:0] : nfull;
        dlast = (r_cur + CURW'(ncell)) == CURW'(CPB);
        c2    = (COLW+1)'(r_col) + (COLW+1)'(ncell);

        n_u0 = r_u0; n_u1 = r_u1; n_v0 = r_v0; n_v1 = r_v1;
        n_cu = r_cu; n_cv = r_cv; n_wv = r_wv; n_ua = r_ua;
        n_cur = r_cur; n_col = r_col; n_addr = r_addr; n_bpc = r_bpc;

        op        = '0;
        op.kind   = K_NOP;
        op.status = ST_REJECT;
        op.fill   = r_fill;

        unique case (t_action'(i_in.action))
            ACT_WINDOW: begin
                if (win_bad) begin
                    n_wv = 1'b0;
                end else begin
                    n_u0 = XW'(u0); n_u1 = XW'(u1);
                    n_v0 = YW'(v0); n_v1 = YW'(v1);
                    n_cu = XW'(u0); n_cv = YW'(v0);
                    n_wv = type_ok;
                    if (map_rst) begin
                        op.kind = K_CLEAR;
                    end
                    if (type_ok) begin
                        op.status = map_rst ? ST_RESET : ST_OK;
                    end
                end
            end
            ACT_SEQ: begin
                if (cmp_ok) begin
                    op.kind     = K_CMP;
                    op.seq      = i_in.seq_value;
                    op.blk_addr = 14'(BAW'(BAW'(r_cv) * BLOCKS_X + BAW'(r_cu)));
                    op.rx       = 8'($signed(10'(r_cu)) - HXS);
                    op.ry       = 8'($signed(10'(r_cv)) - HYS);
                    op.last     = (r_cu + XW'(1) == r_u1) && (r_cv + YW'(1) == r_v1);
                    if (r_cu + XW'(1) == r_u1) begin
                        n_cu = r_u0;
                        n_cv = r_cv + YW'(1);
                    end else begin
                        n_cu = r_cu + XW'(1);
                    end
                end
            end
            ACT_HEADER: begin
                if (hdr_ok) begin
                    op.kind     = K_WRSEQ;
                    op.status   = ST_OK;
                    op.seq      = i_in.seq_value;
                    op.blk_addr = 14'(BAW'(BAW'(hv[YW-1:0]) * BLOCKS_X
                                           + BAW'(hu[XW-1:0])));
                    n_ua   = 1'b1;
                    n_cur  = '0;
                    n_col  = '0;
                    n_bpc  = i_in.bits_per_cell;
                    n_addr = CAW'(CAW'(hv[YW-1:0]) * (BLOCK_SIZE * MAP_W)
                                  + CAW'(hu[XW-1:0]) * BLOCK_SIZE);
                end
            end
            default: begin
                if (r_ua) begin
                    op.kind      = K_UNPACK;
                    op.status    = ST_OK;
                    op.last      = dlast;
                    op.cell_addr = 26'(r_addr);
                    op.col       = 6'(r_col);
                    op.ncell     = ncell;
                    op.bpc       = r_bpc;
                    op.pbyte     = i_in.packed_byte;
                    if (dlast) begin
                        n_ua  = 1'b0;
                        n_cur = '0;
                    end else begin
                        n_cur = r_cur + CURW'(ncell);
                        if (c2 >= (COLW+1)'(BLOCK_SIZE)) begin
                            n_col  = COLW'(c2 - (COLW+1)'(BLOCK_SIZE));
                            n_addr = r_addr + CAW'(ncell) + CAW'(MAP_W - BLOCK_SIZE);
                        end else begin
                            n_col  = COLW'(c2);
                            n_addr = r_addr + CAW'(ncell);
                        end
                    end
                end
            end
        endcase
    end

    assign o_push = acc;
    assign o_op   = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own  <= '0;
            r_fill <= '0;
            r_u0   <= XW'(BLOCKS_X / 2);
            r_u1   <= XW'(BLOCKS_X / 2);
            r_v0   <= YW'(BLOCKS_Y / 2);
            r_v1   <= YW'(BLOCKS_Y / 2);
            r_cu   <= '0;
            r_cv   <= '0;
            r_wv   <= 1'b0;
            r_ua   <= 1'b0;
            r_cur  <= '0;
            r_col  <= '0;
            r_addr <= '0;
            r_bpc  <= 4'd1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_OWN_TYPE) begin
                    r_own <= i_cfg_data;
                end else begin
                    r_fill <= i_cfg_data;
                end
            end
            if (acc) begin
                r_u0 <= n_u0; r_u1 <= n_u1; r_v0 <= n_v0; r_v1 <= n_v1;
                r_cu <= n_cu; r_cv <= n_cv; r_wv <= n_wv; r_ua <= n_ua;
                r_cur <= n_cur; r_col <= n_col; r_addr <= n_addr; r_bpc <= n_bpc;
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/bmst_back.sv */
`default_nettype none
module bmst_back #(
    parameter int BLOCK_SIZE = 16,
    parameter int BLOCKS_X   = 32,
    parameter int BLOCKS_Y   = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire bmst_pkg::t_op i_op,
    output logic               o_pop,
    output logic               o_init,
    bmst_out_if.source         o_out
);
    import bmst_pkg::*;

    localparam int MAP_W      = BLOCKS_X * BLOCK_SIZE;
    localparam int NUM_BLOCKS = BLOCKS_X * BLOCKS_Y;
    localparam int NUM_CELLS  = NUM_BLOCKS * BLOCK_SIZE * BLOCK_SIZE;
    localparam int COLW       = $clog2(BLOCK_SIZE);
    localparam int CAW        = $clog2(NUM_CELLS);
    localparam int BAW        = $clog2(NUM_BLOCKS);

    t_bstate        r_state, n_state;
    t_op            r_op, n_op;
    logic [CAW-1:0] r_clr, n_clr;
    logic [3:0]     r_k, n_k;
    logic [CAW-1:0] r_addr, n_addr;
    logic [COLW-1:0] r_col, n_col;
    logic [7:0]     r_byte, n_byte;
    logic [7:0]     r_fill, n_fill;
    logic           r_init, n_init;
    logic           r_o_valid, n_o_valid;
    logic [2:0]     r_o_status, n_o_status;
    logic signed [7:0] r_o_x, n_o_x, r_o_y, n_o_y;
    logic           r_o_last, n_o_last;

    logic           tbl_we, cel_we;
    logic [BAW-1:0] tbl_addr;
    logic [15:0]    tbl_wdata, tbl_rdata;
    logic [CAW-1:0] cel_addr;
    logic [7:0]     cel_wdata, mask;
    logic           out_free, clr_end;

    assign out_free = !r_o_valid || o_out.ready;
    assign clr_end  = (r_clr == CAW'(NUM_CELLS - 1));

    always_comb begin
        unique case (r_op.bpc)
            4'd1:    mask = 8'h01;
            4'd2:    mask = 8'h03;
            4'd4:    mask = 8'h0f;
            default: mask = 8'hff;
        endcase
    end

    // next state and datapath registers
    always_comb begin
        n_state = r_state; n_op = r_op; n_clr = r_clr; n_k = r_k;
        n_addr = r_addr; n_col = r_col; n_byte = r_byte; n_fill = r_fill;
        n_init = r_init;
        n_o_valid = (r_o_valid && !o_out.ready);
        n_o_status = r_o_status; n_o_x = r_o_x; n_o_y = r_o_y; n_o_last = r_o_last;

        unique case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    n_op = i_op;
                    unique case (i_op.kind)
                        K_CLEAR: begin
                            n_state = BS_CLEAR;
                            n_clr   = '0;
                            n_fill  = i_op.fill;
                        end
                        K_CMP:    n_state = BS_CMP_RD;
                        K_WRSEQ:  n_state = BS_WSEQ;
                        K_UNPACK: begin
                            n_state = BS_UNPACK;
                            n_k     = '0;
                            n_addr  = i_op.cell_addr[CAW-1:0];
                            n_col   = i_op.col[COLW-1:0];
                            n_byte  = i_op.pbyte;
                        end
                        default:  n_state = BS_EMIT;
                    endcase
                end
            end
            BS_CLEAR: begin
                n_clr = r_clr + CAW'(1);
                if (clr_end) begin
                    n_init  = 1'b0;
                    n_state = r_init ? BS_IDLE : BS_EMIT;
                end
            end
            BS_CMP_RD: n_state = BS_CMP_CHK;
            BS_CMP_CHK: begin
                if (tbl_rdata != r_op.seq) begin
                    n_op.status = ST_REQ;
                end else begin
                    n_op.status = ST_SKIP;
                    n_op.rx     = '0;
                    n_op.ry     = '0;
                end
                n_state = BS_EMIT;
            end
            BS_WSEQ: n_state = BS_EMIT;
            BS_UNPACK: begin
                n_k    = r_k + 4'd1;
                n_byte = r_byte >> r_op.bpc;
                if (r_col == COLW'(BLOCK_SIZE - 1)) begin
                    n_col  = '0;
                    n_addr = r_addr + CAW'(MAP_W - BLOCK_SIZE + 1);
                end else begin
                    n_col  = r_col + COLW'(1);
                    n_addr = r_addr + CAW'(1);
                end
                if (r_k + 4'd1 == r_op.ncell) begin
                    n_state = BS_EMIT;
                end
            end
            default: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_op.status;
                    n_o_x      = r_op.rx;
                    n_o_y      = r_op.ry;
                    n_o_last   = r_op.last;
                    n_state    = BS_IDLE;
                end
            end
        endcase
    end

    // memory controls
    always_comb begin
        o_pop     = 1'b0;
        tbl_we    = 1'b0;
        tbl_addr  = r_op.blk_addr[BAW-1:0];
        tbl_wdata = r_op.seq;
        cel_we    = 1'b0;
        cel_addr  = r_addr;
        cel_wdata = r_byte & mask;
        unique case (r_state)
            BS_IDLE: o_pop = !i_q_empty;
            BS_CLEAR: begin
                cel_we    = 1'b1;
                cel_addr  = r_clr;
                cel_wdata = r_fill;
                tbl_we    = (r_clr < CAW'(NUM_BLOCKS));
                tbl_addr  = r_clr[BAW-1:0];
                tbl_wdata = '0;
            end
            BS_WSEQ:   tbl_we = 1'b1;
            BS_UNPACK: cel_we = 1'b1;
            default: ;
        endcase
    end

    bmst_ram #(.WIDTH(16), .DEPTH(NUM_BLOCKS)) u_seq_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_addr  (tbl_addr),
        .i_wdata (tbl_wdata),
        .o_rdata (tbl_rdata)
    );

    bmst_ram #(.WIDTH(8), .DEPTH(NUM_CELLS)) u_cells (
        .i_clk   (i_clk),
        .i_we    (cel_we),
        .i_addr  (cel_addr),
        .i_wdata (cel_wdata),
        .o_rdata ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_CLEAR;
            r_clr     <= '0;
            r_fill    <= '0;
            r_init    <= 1'b1;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_fill    <= n_fill;
            r_init    <= n_init;
            r_o_valid <= n_o_valid;
        end
        r_op       <= n_op;
        r_k        <= n_k;
        r_addr     <= n_addr;
        r_col      <= n_col;
        r_byte     <= n_byte;
        r_o_status <= n_o_status;
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_last   <= n_o_last;
    end

    assign o_init         = r_init;
    assign o_out.valid    = r_o_valid;
    assign o_out.status   = r_o_status;
    assign o_out.req_x    = r_o_x;
    assign o_out.req_y    = r_o_y;
    assign o_out.run_last = r_o_last;
endmodule
`default_nettype wire
